/* src/clsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package clsu_pkg;

  localparam int OpWidth     = 2;
  localparam int ValueWidth  = 32;
  localparam int IndexWidth  = 8;
  localparam int StatusWidth = 2;
  localparam int PosWidth    = 4;
  localparam int CountWidth  = 5;
  localparam int MaxResults  = 16;

  localparam int InDataWidth  = 40;  // value, index
  localparam int OutDataWidth = 48;  // item, position, count, zero fill

  localparam logic [OpWidth-1:0] OP_APPEND = 2'd0;
  localparam logic [OpWidth-1:0] OP_REMOVE = 2'd1;
  localparam logic [OpWidth-1:0] OP_DUMP   = 2'd2;

  localparam logic [StatusWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatusWidth-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusWidth-1:0] ST_RANGE = 2'd2;
  localparam logic [StatusWidth-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic                   load_in;
    logic                   wr_en;
    logic                   wr_shift;   // write rd_data at ptr, else value at count
    logic                   rd_en;
    logic                   rd_next;    // read at ptr + 1, else at ptr
    logic                   ptr_clr;
    logic                   ptr_index;
    logic                   ptr_inc;
    logic                   cnt_inc;
    logic                   cnt_dec;
    logic                   out_load;
    logic                   out_dump;   // item from the read port, position from ptr
    logic [StatusWidth-1:0] out_status;
    logic                   out_last;
  } cmd_t;

  typedef struct packed {
    logic [OpWidth-1:0] op;
    logic               full;
    logic               oob;
    logic               idx_last;
    logic               empty;
    logic               shift_done;
    logic               dump_last;
    logic               out_free;
  } sts_t;

endpackage

`default_nettype wire

/* src/clsu_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module clsu_datapath #(
  parameter int CAPACITY = 16
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire clsu_pkg::cmd_t               cmd,
  output clsu_pkg::sts_t                    sts,
  input  wire  [clsu_pkg::OpWidth-1:0]      in_op,
  input  wire  [clsu_pkg::ValueWidth-1:0]   in_value,
  input  wire  [clsu_pkg::IndexWidth-1:0]   in_index,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [clsu_pkg::StatusWidth-1:0]  out_status,
  output logic [clsu_pkg::ValueWidth-1:0]   out_item,
  output logic [clsu_pkg::PosWidth-1:0]     out_position,
  output logic [clsu_pkg::CountWidth-1:0]   out_count,
  output logic                              out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [clsu_pkg::ValueWidth-1:0] mem [CAPACITY];
  logic [clsu_pkg::ValueWidth-1:0] rd_data;

  logic [clsu_pkg::OpWidth-1:0]    op_q;
  logic [clsu_pkg::ValueWidth-1:0] value_q;
  logic [clsu_pkg::IndexWidth-1:0] index_q;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [AW-1:0] ptr;
  logic [AW-1:0] ptr_p1;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [clsu_pkg::ValueWidth-1:0] wr_data;

  assign ptr_p1  = ptr + AW'(1);
  assign rd_addr = cmd.rd_next ? ptr_p1 : ptr;
  assign wr_addr = cmd.wr_shift ? ptr : count[AW-1:0];
  assign wr_data = cmd.wr_shift ? rd_data : value_q;

  always_comb begin
    count_next = count;
    if (cmd.cnt_inc) begin
      count_next = count + CW'(1);
    end else if (cmd.cnt_dec) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q    <= in_op;
      value_q <= in_value;
      index_q <= in_index;
    end
    if (cmd.ptr_clr) begin
      ptr <= '0;
    end else if (cmd.ptr_index) begin
      ptr <= index_q[AW-1:0];
    end else if (cmd.ptr_inc) begin
      ptr <= ptr_p1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // result register: one request waits here while the next one is worked on
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status   <= cmd.out_status;
      out_item     <= cmd.out_dump ? rd_data : '0;
      out_position <= cmd.out_dump ? clsu_pkg::PosWidth'(ptr) : '0;
      out_count    <= clsu_pkg::CountWidth'(count_next);
      out_last     <= cmd.out_last;
    end
  end

  always_comb begin
    sts.op         = op_q;
    sts.full       = (count == CW'(CAPACITY));
    sts.oob        = (index_q >= clsu_pkg::IndexWidth'(count));
    sts.idx_last   = ((32'(index_q) + 32'd1) == 32'(count));
    sts.empty      = (count == '0);
    sts.shift_done = ((32'(ptr) + 32'd2) == 32'(count));
    sts.dump_last  = ((32'(ptr) + 32'd1) == 32'(count)) ||
                     ((32'(ptr) + 32'd1) == 32'(clsu_pkg::MaxResults));
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

/* src/clsu_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module clsu_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire clsu_pkg::sts_t sts,
  output clsu_pkg::cmd_t      cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DECODE   = 7'b0000010,
    S_SHIFT_RD = 7'b0000100,
    S_SHIFT_WR = 7'b0001000,
    S_REM_DONE = 7'b0010000,
    S_DUMP_RD  = 7'b0100000,
    S_DUMP_OUT = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        priority case (sts.op)
          clsu_pkg::OP_APPEND: begin
            if (sts.out_free) begin
              cmd.out_load = 1'b1;
              cmd.out_last = 1'b1;
              if (sts.full) begin
                cmd.out_status = clsu_pkg::ST_FULL;
              end else begin
                cmd.out_status = clsu_pkg::ST_OK;
                cmd.wr_en      = 1'b1;
                cmd.cnt_inc    = 1'b1;
              end
              state_next = S_IDLE;
            end
          end
          clsu_pkg::OP_REMOVE: begin
            if (sts.oob) begin
              if (sts.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = clsu_pkg::ST_RANGE;
                state_next     = S_IDLE;
              end
            end else if (sts.idx_last) begin
              // tail entry: nothing to move down
              if (sts.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = clsu_pkg::ST_OK;
                cmd.cnt_dec    = 1'b1;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.ptr_index = 1'b1;
              state_next    = S_SHIFT_RD;
            end
          end
          clsu_pkg::OP_DUMP: begin
            if (sts.empty) begin
              if (sts.out_free) begin
                cmd.out_load   = 1'b1;
                cmd.out_last   = 1'b1;
                cmd.out_status = clsu_pkg::ST_EMPTY;
                state_next     = S_IDLE;
              end
            end else begin
              cmd.ptr_clr = 1'b1;
              state_next  = S_DUMP_RD;
            end
          end
          default: begin
            if (sts.out_free) begin
              cmd.out_load   = 1'b1;
              cmd.out_last   = 1'b1;
              cmd.out_status = clsu_pkg::ST_OK;
              state_next     = S_IDLE;
            end
          end
        endcase
      end
      S_SHIFT_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_next  = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_shift = 1'b1;
        if (sts.shift_done) begin
          state_next = S_REM_DONE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_next  = S_SHIFT_RD;
        end
      end
      S_REM_DONE: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = clsu_pkg::ST_OK;
          cmd.cnt_dec    = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_dump   = 1'b1;
          cmd.out_status = clsu_pkg::ST_OK;
          cmd.out_last   = sts.dump_last;
          if (sts.dump_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.ptr_inc = 1'b1;
            state_next  = S_DUMP_RD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/compacting_list_store_unit.sv */
// Results: append, failed remove, tail remove, empty dump and unused codes each give
//   one result, loaded into the result register from the decode state; a remove that
//   closes a gap first moves each later entry down, one memory read and one write per
//   moved entry. A new request is taken only from the idle state, after the last one's
//   result is loaded; a dump gives its results in turn (read port then result register).
// Reset: rst synchronous, active high; clears the count and the handshakes.
`timescale 1ns / 1ps
`default_nettype none

module compacting_list_store_unit #(
  parameter int CAPACITY = 16
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [clsu_pkg::InDataWidth-1:0]     s_axis_tdata,  // value[31:0], index[39:32]
  input  wire  [clsu_pkg::OpWidth-1:0]         s_axis_tuser,  // op[1:0]
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // item[31:0], position[35:32], count[40:36], zero[47:41]
  output logic [clsu_pkg::OutDataWidth-1:0]    m_axis_tdata,
  output logic [clsu_pkg::StatusWidth-1:0]     m_axis_tuser,  // status[1:0]
  output logic                                 m_axis_tlast
);

  clsu_pkg::cmd_t cmd;
  clsu_pkg::sts_t sts;

  logic [clsu_pkg::ValueWidth-1:0] out_item;
  logic [clsu_pkg::PosWidth-1:0]   out_position;
  logic [clsu_pkg::CountWidth-1:0] out_count;

  clsu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  clsu_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (s_axis_tuser),
    .in_value     (s_axis_tdata[31:0]),
    .in_index     (s_axis_tdata[39:32]),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_status   (m_axis_tuser),
    .out_item     (out_item),
    .out_position (out_position),
    .out_count    (out_count),
    .out_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, out_count, out_position, out_item};

endmodule

`default_nettype wire

/* src/clsu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module clsu_checker #(
  parameter int CAPACITY = 16
) (
  input wire                               clk,
  input wire                               rst,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [clsu_pkg::OutDataWidth-1:0]  m_axis_tdata,
  input wire [clsu_pkg::StatusWidth-1:0]   m_axis_tuser,
  input wire                               m_axis_tlast
);

  logic [clsu_pkg::CountWidth-1:0] res_count;
  logic [clsu_pkg::ValueWidth-1:0] res_item;

  assign res_count = m_axis_tdata[40:36];
  assign res_item  = m_axis_tdata[31:0];

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (CAPACITY > 31) || (res_count <= clsu_pkg::CountWidth'(CAPACITY)))
    else $error("count beyond capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == clsu_pkg::ST_FULL)
      |-> res_count == clsu_pkg::CountWidth'(CAPACITY) && m_axis_tlast)
    else $error("full status with list not full");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == clsu_pkg::ST_EMPTY)
      |-> res_count == '0 && res_item == '0 && m_axis_tlast)
    else $error("empty status with entries or data");

  a_no_request_in_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid straight after reset");

endmodule

bind compacting_list_store_unit clsu_checker #(
  .CAPACITY (CAPACITY)
) u_clsu_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* sim/tb_compacting_list_store_unit.sv */
`timescale 1ns / 1ps

module tb_compacting_list_store_unit;
  import clsu_pkg::*;

  localparam int CAPACITY  = 16;
  localparam int HOLD_LEN  = 200;
  localparam int WDOG_MAX  = 5000;
  localparam int TAIL_WAIT = 60;
  localparam logic [OpWidth-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [StatusWidth-1:0] status;
    logic [ValueWidth-1:0]  item;
    logic [PosWidth-1:0]    position;
    logic [CountWidth-1:0]  count;
    logic                   last;
  } list_result_t;

  typedef struct {
    logic [OpWidth-1:0]     op;
    logic [ValueWidth-1:0]  value;
    logic [IndexWidth-1:0]  index;
    bit                     typed;
    logic [StatusWidth-1:0] status;
    logic [CountWidth-1:0]  count;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataWidth-1:0] s_axis_tdata = '0;
  logic [OpWidth-1:0] s_axis_tuser = OP_APPEND;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic [StatusWidth-1:0] m_axis_tuser;
  logic m_axis_tlast;

  // shadow of the list
  logic [ValueWidth-1:0] list_mem [CAPACITY];
  int list_len = 0;

  list_result_t pending_results[$];
  dir_row_t dir_rows[$];
  int mismatch_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  compacting_list_store_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // value[31:0], index[39:32]
    .s_axis_tuser (s_axis_tuser),   // op[1:0]
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // item[31:0], position[35:32], count[40:36], zero[47:41]
    .m_axis_tuser (m_axis_tuser),   // status[1:0]
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // Apply one request to the shadow list and queue the results it causes.
  task automatic apply_list_op(input logic [OpWidth-1:0] op,
                               input logic [ValueWidth-1:0] value,
                               input logic [IndexWidth-1:0] index,
                               ref list_result_t res[$]);
    list_result_t r;
    int i;
    int n;
    r = '{status: ST_OK, item: '0, position: '0, count: '0, last: 1'b1};
    case (op)
      OP_APPEND: begin
        if (list_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          list_mem[list_len] = value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (int'(index) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(index); i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
          list_len--;
        end
      end
      OP_DUMP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          n = (list_len > MaxResults) ? MaxResults : list_len;
          for (i = 0; i < n; i++) begin
            r.item     = list_mem[i];
            r.position = i[PosWidth-1:0];
            r.count    = list_len[CountWidth-1:0];
            r.last     = (i + 1 == n);
            res.push_back(r);
          end
          return;
        end
      end
      default: ;
    endcase
    r.count = list_len[CountWidth-1:0];
    res.push_back(r);
  endtask

  // Offer one request; valid stays high into the next request when no gap is drawn.
  task automatic send_req(input logic [OpWidth-1:0] op,
                          input logic [ValueWidth-1:0] value,
                          input logic [IndexWidth-1:0] index,
                          input bit typed,
                          input logic [StatusWidth-1:0] typed_status,
                          input logic [CountWidth-1:0] typed_count);
    list_result_t res[$];
    while ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {index, value};
    do @(posedge clk); while (!s_axis_tready);
    apply_list_op(op, value, index, res);
    if (typed) begin
      pending_results.push_back('{status: typed_status, item: '0, position: '0,
                                  count: typed_count, last: 1'b1});
    end else begin
      foreach (res[k]) pending_results.push_back(res[k]);
    end
  endtask

  task automatic add_row(input logic [OpWidth-1:0] op, input logic [ValueWidth-1:0] value,
                         input logic [IndexWidth-1:0] index, input bit typed,
                         input logic [StatusWidth-1:0] status,
                         input logic [CountWidth-1:0] count);
    dir_rows.push_back('{op: op, value: value, index: index, typed: typed,
                         status: status, count: count});
  endtask

  // Mostly well-formed traffic: valid removes and appends, with dumps, misses and noise.
  task automatic send_random;
    int pick;
    logic [ValueWidth-1:0] v;
    logic [IndexWidth-1:0] idx;
    pick = $urandom_range(0, 99);
    v    = $urandom;
    idx  = IndexWidth'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
    if (pick < 45) begin
      send_req(OP_APPEND, v, idx, 1'b0, ST_OK, '0);
    end else if (pick < 75) begin
      if (list_len > 0) idx = IndexWidth'($urandom_range(0, list_len - 1));
      send_req(OP_REMOVE, v, idx, 1'b0, ST_OK, '0);
    end else if (pick < 88) begin
      send_req(OP_DUMP, v, idx, 1'b0, ST_OK, '0);
    end else if (pick < 96) begin
      idx = IndexWidth'($urandom_range(list_len, 255));
      send_req(OP_REMOVE, v, idx, 1'b0, ST_OK, '0);
    end else begin
      send_req(OP_UNUSED, v, idx, 1'b0, ST_OK, '0);
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen     <= hold_seq;
      hold_left     <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Result checker
  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tuser, item: m_axis_tdata[31:0], position: m_axis_tdata[35:32],
              count: m_axis_tdata[40:36], last: m_axis_tlast};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: st=%0d item=%h pos=%0d cnt=%0d last=%0d",
                   got.status, got.item, got.position, got.count, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got !== want || m_axis_tdata[47:41] !== '0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: exp st=%0d item=%h pos=%0d cnt=%0d last=%0d",
                     want.status, want.item, want.position, want.count, want.last);
            $display("          got st=%0d item=%h pos=%0d cnt=%0d last=%0d pad=%h",
                     got.status, got.item, got.position, got.count, got.last,
                     m_axis_tdata[47:41]);
          end
        end
      end
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_MAX) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    // empty-list cases, extremes, bounds, then fill to capacity, overflow, dump and removes
    add_row(OP_DUMP,   32'h0,         8'd0,   1'b1, ST_EMPTY, 5'd0);
    add_row(OP_REMOVE, 32'h0,         8'd0,   1'b1, ST_RANGE, 5'd0);
    add_row(OP_UNUSED, 32'hffff_ffff, 8'd255, 1'b1, ST_OK,    5'd0);
    add_row(OP_APPEND, 32'h8000_0000, 8'd255, 1'b1, ST_OK,    5'd1);
    add_row(OP_APPEND, 32'h7fff_ffff, 8'd0,   1'b1, ST_OK,    5'd2);
    add_row(OP_DUMP,   32'h0,         8'd0,   1'b0, ST_OK,    5'd0);
    add_row(OP_REMOVE, 32'h0,         8'd2,   1'b1, ST_RANGE, 5'd2);
    add_row(OP_REMOVE, 32'h0,         8'd255, 1'b1, ST_RANGE, 5'd2);
    add_row(OP_REMOVE, 32'h0,         8'd0,   1'b0, ST_OK,    5'd0);
    for (int i = 0; i < CAPACITY - 1; i++)
      add_row(OP_APPEND, (i[0] ? 32'hffff_ffff : 32'h0) ^ (32'h1 << (2 * i)), 8'd0,
              1'b1, ST_OK, 5'(i + 2));
    add_row(OP_APPEND, 32'h1234_5678, 8'd0,  1'b1, ST_FULL, 5'd16);
    add_row(OP_DUMP,   32'h0,         8'd0,  1'b0, ST_OK,   5'd0);
    add_row(OP_REMOVE, 32'h0,         8'd15, 1'b0, ST_OK,   5'd0);
    add_row(OP_REMOVE, 32'h0,         8'd0,  1'b0, ST_OK,   5'd0);
    add_row(OP_DUMP,   32'h0,         8'd0,  1'b0, ST_OK,   5'd0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[r])
      send_req(dir_rows[r].op, dir_rows[r].value, dir_rows[r].index, dir_rows[r].typed,
               dir_rows[r].status, dir_rows[r].count);

    // idle_pct is read by this process only
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct <= 0;  end
        1: begin idle_pct = 69; stall_pct <= 0;  end
        2: begin idle_pct = 0;  stall_pct <= 69; end
        3: begin idle_pct = 34; stall_pct <= 34; end
        default: begin
          // long receiver hold-off while requests keep coming
          idle_pct = 0;
          stall_pct <= 0;
          hold_seq <= hold_seq + 1;
        end
      endcase
      repeat (14) send_random();
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatch_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
